FILE: rtl/core/p256der_pkg.sv
// Shared constants, types and helpers for the P-256 low-s DER signature encoder.
package p256der_pkg;

    localparam int VAL_W   = 256;
    localparam int TLV_W   = 280;
    localparam int BUF_W   = 576;
    localparam int WORD_W  = 64;

    localparam logic [VAL_W-1:0] ORDER_N =
        256'hFFFFFFFF00000000FFFFFFFFFFFFFFFFBCE6FAADA7179E84F3B9CAC2FC632551;
    localparam logic [VAL_W-1:0] HALF_N = ORDER_N >> 1;

    localparam logic [7:0] TAG_SEQ = 8'h30;
    localparam logic [7:0] TAG_INT = 8'h02;
    localparam logic [7:0] PAD_BYTE = 8'h00;

    typedef struct packed {
        logic [TLV_W-1:0] tlv;
        logic [5:0]       len;
    } tlv_t;

    function automatic logic [5:0] clz32(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  n;
        x = v;
        n = 6'd0;
        if (v == 32'd0) begin
            n = 6'd32;
        end else begin
            if (x[31:16] == 16'd0) begin n = n + 6'd16; x = x << 16; end
            if (x[31:24] == 8'd0) begin n = n + 6'd8; x = x << 8; end
            if (x[31:28] == 4'd0) begin n = n + 6'd4; x = x << 4; end
            if (x[31:30] == 2'd0) begin n = n + 6'd2; x = x << 2; end
            if (!x[31]) begin n = n + 6'd1; end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/p256der_lows.sv
// Low-s normalization of s: compare against n/2 and n, then fold into range.
module p256der_lows (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [p256der_pkg::VAL_W-1:0] in_r,
    input  logic [p256der_pkg::VAL_W-1:0] in_s,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [p256der_pkg::VAL_W-1:0] out_r,
    output logic [p256der_pkg::VAL_W-1:0] out_s
);
    import p256der_pkg::*;

    logic             v1_reg, v2_reg;
    logic [VAL_W-1:0] r1_reg, s1_reg, r2_reg, s2_reg;
    logic             gt_half_reg, gt_n_reg;
    logic             rdy1, rdy2;
    logic [VAL_W-1:0] sub_a, sub_b, s2_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        sub_a   = gt_n_reg ? s1_reg : ORDER_N;
        sub_b   = gt_n_reg ? ORDER_N : s1_reg;
        s2_next = gt_half_reg ? (sub_a - sub_b) : s1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            r1_reg      <= in_r;
            s1_reg      <= in_s;
            gt_half_reg <= in_s > HALF_N;
            gt_n_reg    <= in_s > ORDER_N;
        end
        if (rdy2 && v1_reg) begin
            r2_reg <= r1_reg;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_r     = r2_reg;
    assign out_s     = s2_reg;

`ifndef SYNTHESIS
    a_s_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (s2_reg <= HALF_N))
        else $error("normalized s above n/2");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !out_ready) |=> (v2_reg && $stable(s2_reg)))
        else $error("stage 2 changed while stalled");
    a_fold_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2 && !gt_half_reg) |=> (s2_reg == $past(s1_reg)))
        else $error("s altered though within n/2");
`endif

endmodule

FILE: rtl/core/p256der_lane.sv
// One integer lane: strip leading zero bytes and build a left-aligned INTEGER TLV.
module p256der_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [p256der_pkg::VAL_W-1:0] in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output p256der_pkg::tlv_t             out_tlv
);
    import p256der_pkg::*;

    logic             va_reg, vb_reg;
    logic [VAL_W-1:0] val_reg;
    logic [5:0]       lz_reg;
    logic             rdy_a, rdy_b;
    logic [31:0]      nz;
    logic [VAL_W-1:0] shifted;
    logic [5:0]       len;
    logic             pad;
    tlv_t             tlv_next, tlv_reg;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb begin
        for (int j = 0; j < 32; j++) begin
            nz[j] = |in_value[8*j +: 8];
        end
    end

    always_comb begin
        shifted = val_reg << {lz_reg, 3'b000};
        len     = 6'd32 - lz_reg;
        pad     = (lz_reg == 6'd32) || shifted[VAL_W-1];
        if (pad) begin
            tlv_next.tlv = {TAG_INT, {2'b00, len} + 8'd1, PAD_BYTE, shifted};
        end else begin
            tlv_next.tlv = {TAG_INT, {2'b00, len}, shifted, 8'h00};
        end
        tlv_next.len = len + 6'd2 + {5'd0, pad};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            val_reg <= in_value;
            lz_reg  <= clz32(nz);
        end
        if (rdy_b && va_reg) begin
            tlv_reg <= tlv_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_tlv   = tlv_reg;

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vb_reg |-> (tlv_reg.len >= 6'd3 && tlv_reg.len <= 6'd35))
        else $error("TLV length out of range");
    a_lz_range: assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg |-> (lz_reg <= 6'd32))
        else $error("leading zero count out of range");
    a_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        vb_reg |-> (tlv_reg.tlv[TLV_W-1 -: 8] == TAG_INT))
        else $error("TLV tag missing");
`endif

endmodule

FILE: rtl/core/p256der_merge.sv
// Merge the two lane TLVs under a SEQUENCE header and emit 64-bit words.
module p256der_merge (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  p256der_pkg::tlv_t              in_r,
    input  p256der_pkg::tlv_t              in_s,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [p256der_pkg::WORD_W-1:0] out_bytes,
    output logic [3:0]                     out_count,
    output logic                           out_last
);
    import p256der_pkg::*;

    logic             busy_reg;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [6:0]       rem_reg, rem_next;
    logic [6:0]       seq_len;
    logic [9:0]       s_shift;
    logic             load, pop;

    always_comb begin
        seq_len  = {1'b0, in_r.len} + {1'b0, in_s.len};
        rem_next = seq_len + 7'd2;
        s_shift  = ({4'd0, in_r.len} + 10'd2) << 3;
        buf_next = {TAG_SEQ, {1'b0, seq_len}, in_r.tlv, {TLV_W{1'b0}}}
                 | ({in_s.tlv, {(BUF_W-TLV_W){1'b0}}} >> s_shift);
    end

    assign out_valid = busy_reg;
    assign out_bytes = buf_reg[BUF_W-1 -: WORD_W];
    assign out_count = (rem_reg >= 7'd8) ? 4'd8 : rem_reg[3:0];
    assign out_last  = rem_reg <= 7'd8;
    assign pop       = busy_reg && out_ready;
    assign in_ready  = !busy_reg || (out_ready && out_last);
    assign load      = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (pop && out_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= buf_next;
            rem_reg <= rem_next;
        end else if (pop) begin
            buf_reg <= buf_reg << WORD_W;
            rem_reg <= rem_reg - 7'd8;
        end
    end

`ifndef SYNTHESIS
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg >= 7'd1 && rem_reg <= 7'd72))
        else $error("byte count out of range while busy");
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !out_last) |=> (busy_reg && rem_reg == $past(rem_reg) - 7'd8))
        else $error("serializer did not advance by one word");
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (rem_reg >= 7'd8 && buf_reg[BUF_W-1 -: 8] == TAG_SEQ))
        else $error("bad encoding header on load");
`endif

endmodule

FILE: rtl/core/ecdsa_p256_low_s_der_encoder_top.sv
// Top level of the ECDSA P-256 low-s DER signature encoder.
//
// Slave channel: one word per signature, s_tdata carries r and s as eight
// 64-bit fields. Master channel: the DER encoding, eight bytes per word,
// first byte in bits 63..56, a byte count on each word, tlast on the last.
// s is folded to n - s (or s - n when above n) whenever it exceeds n/2.
// The input passes two normalization stages and two lane stages, then the
// word serializer registers the first output word.
// Throughput is set by the serializer, which sends one output word per
// cycle while m_tready is high, one to nine words per signature. The input
// side accepts while words wait, until the five pipeline stages are full.
// Reset (aresetn low at a clock edge) empties every stage and drops any
// encoding in flight. When m_tready is low the current word holds and the
// pipeline fills behind it, then s_tready falls.
module ecdsa_p256_low_s_der_encoder_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // r_word_3, r_word_2, r_word_1, r_word_0, s_word_3, s_word_2, s_word_1, s_word_0
    input  logic [511:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // der_bytes [63:0], byte_count [67:64], zero fill [71:68]
    output logic [71:0]  m_tdata,
    output logic         m_tlast
);
    import p256der_pkg::*;

    logic             norm_valid, norm_ready;
    logic [VAL_W-1:0] norm_r, norm_s;
    logic             lr_in_ready, ls_in_ready;
    logic             lr_out_valid, ls_out_valid;
    tlv_t             lr_tlv, ls_tlv;
    logic             merge_ready;
    logic [WORD_W-1:0] out_bytes;
    logic [3:0]       out_count;

    p256der_lows u_lows (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_r      ({s_tdata[63:0], s_tdata[127:64], s_tdata[191:128], s_tdata[255:192]}),
        .in_s      ({s_tdata[319:256], s_tdata[383:320], s_tdata[447:384], s_tdata[511:448]}),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_r     (norm_r),
        .out_s     (norm_s)
    );

    assign norm_ready = lr_in_ready && ls_in_ready;

    p256der_lane u_lane_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid && ls_in_ready),
        .in_ready  (lr_in_ready),
        .in_value  (norm_r),
        .out_valid (lr_out_valid),
        .out_ready (merge_ready && ls_out_valid),
        .out_tlv   (lr_tlv)
    );

    p256der_lane u_lane_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid && lr_in_ready),
        .in_ready  (ls_in_ready),
        .in_value  (norm_s),
        .out_valid (ls_out_valid),
        .out_ready (merge_ready && lr_out_valid),
        .out_tlv   (ls_tlv)
    );

    p256der_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lr_out_valid && ls_out_valid),
        .in_ready  (merge_ready),
        .in_r      (lr_tlv),
        .in_s      (ls_tlv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bytes (out_bytes),
        .out_count (out_count),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, out_count, out_bytes};

endmodule
